/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/lrupr_pkg.sv */
package lrupr_pkg;

  localparam int LRUPR_FRAMES       = 4;
  localparam int LRUPR_PAGE_ID_BITS = 8;
  localparam int LRUPR_FAULT_BITS   = 32;

  typedef struct packed {
    logic hit_found;
    logic empty_found;
  } probe_flags_t;

  typedef struct packed {
    logic apply;
    logic clear;
    logic hit;
  } upd_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_HOLD
  } ctrl_state_t;

endpackage

/* hdl/lrupr_if.sv */
interface lrupr_in_if #(
  parameter int PAGE_ID_BITS = lrupr_pkg::LRUPR_PAGE_ID_BITS
);
  logic                    valid;
  logic                    ready;
  logic [PAGE_ID_BITS-1:0] page_id;
  logic                    end_of_string;

  modport source (output valid, page_id, end_of_string, input ready);
  modport sink   (input valid, page_id, end_of_string, output ready);
endinterface

interface lrupr_out_if #(
  parameter int FRAMES       = lrupr_pkg::LRUPR_FRAMES,
  parameter int PAGE_ID_BITS = lrupr_pkg::LRUPR_PAGE_ID_BITS
);
  logic                                   valid;
  logic                                   ready;
  logic                                   hit;
  logic [$clog2(FRAMES)-1:0]              frame;
  logic                                   evicted_valid;
  logic [PAGE_ID_BITS-1:0]                evicted_page;
  logic [lrupr_pkg::LRUPR_FAULT_BITS-1:0] fault_count;

  modport source (output valid, hit, frame, evicted_valid, evicted_page, fault_count,
                  input ready);
  modport sink   (input valid, hit, frame, evicted_valid, evicted_page, fault_count,
                  output ready);
endinterface

/* hdl/lrupr_cell.sv */
module lrupr_cell #(
  parameter int FRAMES       = lrupr_pkg::LRUPR_FRAMES,
  parameter int PAGE_ID_BITS = lrupr_pkg::LRUPR_PAGE_ID_BITS,
  parameter int CELL_IDX     = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tok_i,
  input  lrupr_pkg::probe_flags_t     flags_i,
  input  logic [PAGE_ID_BITS-1:0]     page_i,
  input  logic [$clog2(FRAMES)-1:0]   hit_idx_i,
  input  logic [$clog2(FRAMES)-1:0]   hit_rank_i,
  input  logic [$clog2(FRAMES)-1:0]   empty_idx_i,
  input  logic [$clog2(FRAMES)-1:0]   best_rank_i,
  input  logic [$clog2(FRAMES)-1:0]   victim_idx_i,
  input  logic [PAGE_ID_BITS-1:0]     victim_page_i,
  output logic                        tok_o,
  output lrupr_pkg::probe_flags_t     flags_o,
  output logic [PAGE_ID_BITS-1:0]     page_o,
  output logic [$clog2(FRAMES)-1:0]   hit_idx_o,
  output logic [$clog2(FRAMES)-1:0]   hit_rank_o,
  output logic [$clog2(FRAMES)-1:0]   empty_idx_o,
  output logic [$clog2(FRAMES)-1:0]   best_rank_o,
  output logic [$clog2(FRAMES)-1:0]   victim_idx_o,
  output logic [PAGE_ID_BITS-1:0]     victim_page_o,
  input  lrupr_pkg::upd_cmd_t         cmd_i,
  input  logic [$clog2(FRAMES)-1:0]   slot_i,
  input  logic [$clog2(FRAMES)-1:0]   hit_rank_upd_i,
  input  logic [PAGE_ID_BITS-1:0]     new_page_i
);
  import lrupr_pkg::*;

  localparam int FB = $clog2(FRAMES);
  localparam logic [FB-1:0] MY_IDX = FB'(CELL_IDX);

  logic [PAGE_ID_BITS-1:0] page_r;
  logic                    valid_r;
  logic                    valid_nxt;
  logic [FB-1:0]           rank_r;
  logic [FB-1:0]           rank_nxt;
  logic                    tok_r;

  probe_flags_t            flags_r;
  probe_flags_t            flags_nxt;
  logic [PAGE_ID_BITS-1:0] ppage_r;
  logic [FB-1:0]           hit_idx_r;
  logic [FB-1:0]           hit_idx_nxt;
  logic [FB-1:0]           hit_rank_r;
  logic [FB-1:0]           hit_rank_nxt;
  logic [FB-1:0]           empty_idx_r;
  logic [FB-1:0]           empty_idx_nxt;
  logic [FB-1:0]           best_rank_r;
  logic [FB-1:0]           best_rank_nxt;
  logic [FB-1:0]           victim_idx_r;
  logic [FB-1:0]           victim_idx_nxt;
  logic [PAGE_ID_BITS-1:0] victim_page_r;
  logic [PAGE_ID_BITS-1:0] victim_page_nxt;

  logic hit_here;
  logic empty_here;
  logic vict_here;
  logic is_slot;

  assign hit_here   = valid_r && (page_r == page_i) && !flags_i.hit_found;
  assign empty_here = !valid_r && !flags_i.empty_found;
  assign vict_here  = (CELL_IDX == 0) || (rank_r > best_rank_i);

  always_comb begin
    flags_nxt.hit_found   = flags_i.hit_found || hit_here;
    flags_nxt.empty_found = flags_i.empty_found || empty_here;
    hit_idx_nxt           = hit_here ? MY_IDX : hit_idx_i;
    hit_rank_nxt          = hit_here ? rank_r : hit_rank_i;
    empty_idx_nxt         = empty_here ? MY_IDX : empty_idx_i;
    best_rank_nxt         = vict_here ? rank_r : best_rank_i;
    victim_idx_nxt        = vict_here ? MY_IDX : victim_idx_i;
    victim_page_nxt       = vict_here ? page_r : victim_page_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_i;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_i) begin
      flags_r       <= flags_nxt;
      ppage_r       <= page_i;
      hit_idx_r     <= hit_idx_nxt;
      hit_rank_r    <= hit_rank_nxt;
      empty_idx_r   <= empty_idx_nxt;
      best_rank_r   <= best_rank_nxt;
      victim_idx_r  <= victim_idx_nxt;
      victim_page_r <= victim_page_nxt;
    end
  end

  assign tok_o         = tok_r;
  assign flags_o       = flags_r;
  assign page_o        = ppage_r;
  assign hit_idx_o     = hit_idx_r;
  assign hit_rank_o    = hit_rank_r;
  assign empty_idx_o   = empty_idx_r;
  assign best_rank_o   = best_rank_r;
  assign victim_idx_o  = victim_idx_r;
  assign victim_page_o = victim_page_r;

  assign is_slot = (slot_i == MY_IDX);

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    if (cmd_i.clear) begin
      valid_nxt = 1'b0;
      rank_nxt  = '0;
    end else if (is_slot) begin
      valid_nxt = 1'b1;
      rank_nxt  = '0;
    end else if (valid_r && (!cmd_i.hit || (rank_r < hit_rank_upd_i))) begin
      rank_nxt = rank_r + FB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else if (cmd_i.apply) begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.apply && is_slot && !cmd_i.hit) begin
      page_r <= new_page_i;
    end
  end

endmodule

/* hdl/lru_page_replacement_top.sv */
// Channel   Dir  Beat
// in_ch     in   page_id, end_of_string
// out_ch    out  hit, frame, evicted_valid, evicted_page, fault_count
//
// A reference walks the row of FRAMES cells, one cell per cycle, then the
// frame set is updated from the result that reached the end of the row.
// Synchronous active-low reset empties every frame and zeroes the fault count.
// A result waits in the output register; the next reference is taken meanwhile,
// and the update stalls only while that register is still full.
`include "assert_macros.svh"

module lru_page_replacement_top #(
  parameter int FRAMES       = lrupr_pkg::LRUPR_FRAMES,
  parameter int PAGE_ID_BITS = lrupr_pkg::LRUPR_PAGE_ID_BITS
) (
  input logic          clk,
  input logic          rst_n,
  lrupr_in_if.sink     in_ch,
  lrupr_out_if.source  out_ch
);
  import lrupr_pkg::*;

  localparam int FB = $clog2(FRAMES);
  localparam int CB = LRUPR_FAULT_BITS;

  logic                    tok         [FRAMES+1];
  probe_flags_t            pr_flags    [FRAMES+1];
  logic [PAGE_ID_BITS-1:0] pr_page     [FRAMES+1];
  logic [FB-1:0]           pr_hit_idx  [FRAMES+1];
  logic [FB-1:0]           pr_hit_rank [FRAMES+1];
  logic [FB-1:0]           pr_empty    [FRAMES+1];
  logic [FB-1:0]           pr_best     [FRAMES+1];
  logic [FB-1:0]           pr_victim   [FRAMES+1];
  logic [PAGE_ID_BITS-1:0] pr_vpage    [FRAMES+1];
  logic [FRAMES-1:0]       tok_vec;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  upd_cmd_t    cmd;
  logic        in_acc;
  logic        out_free;
  logic        walk_done;
  logic        end_r;

  logic          dec_hit;
  logic [FB-1:0] dec_slot;
  logic          dec_evict;
  logic [CB-1:0] fault_r;
  logic [CB-1:0] fault_nxt;

  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [FB-1:0]           out_frame_r;
  logic                    out_ev_valid_r;
  logic [PAGE_ID_BITS-1:0] out_ev_page_r;
  logic [CB-1:0]           out_fault_r;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign walk_done = tok[FRAMES];

  assign tok[0]         = in_acc;
  assign pr_flags[0]    = '0;
  assign pr_page[0]     = in_ch.page_id;
  assign pr_hit_idx[0]  = '0;
  assign pr_hit_rank[0] = '0;
  assign pr_empty[0]    = '0;
  assign pr_best[0]     = '0;
  assign pr_victim[0]   = '0;
  assign pr_vpage[0]    = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    assign tok_vec[g] = tok[g+1];
    lrupr_cell #(
      .FRAMES       (FRAMES),
      .PAGE_ID_BITS (PAGE_ID_BITS),
      .CELL_IDX     (g)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .tok_i          (tok[g]),
      .flags_i        (pr_flags[g]),
      .page_i         (pr_page[g]),
      .hit_idx_i      (pr_hit_idx[g]),
      .hit_rank_i     (pr_hit_rank[g]),
      .empty_idx_i    (pr_empty[g]),
      .best_rank_i    (pr_best[g]),
      .victim_idx_i   (pr_victim[g]),
      .victim_page_i  (pr_vpage[g]),
      .tok_o          (tok[g+1]),
      .flags_o        (pr_flags[g+1]),
      .page_o         (pr_page[g+1]),
      .hit_idx_o      (pr_hit_idx[g+1]),
      .hit_rank_o     (pr_hit_rank[g+1]),
      .empty_idx_o    (pr_empty[g+1]),
      .best_rank_o    (pr_best[g+1]),
      .victim_idx_o   (pr_victim[g+1]),
      .victim_page_o  (pr_vpage[g+1]),
      .cmd_i          (cmd),
      .slot_i         (dec_slot),
      .hit_rank_upd_i (pr_hit_rank[FRAMES]),
      .new_page_i     (pr_page[FRAMES])
    );
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      end_r <= in_ch.end_of_string;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_WALK;
      end
      S_WALK: begin
        if (walk_done) state_nxt = out_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    cmd.apply   = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ch.ready = 1'b1;
      S_WALK:  cmd.apply   = walk_done && out_free;
      S_HOLD:  cmd.apply   = out_free;
      default: in_ch.ready = 1'b0;
    endcase
    cmd.clear = end_r;
    cmd.hit   = dec_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign dec_hit   = pr_flags[FRAMES].hit_found;
  assign dec_evict = !dec_hit && !pr_flags[FRAMES].empty_found;

  always_comb begin
    priority if (dec_hit) begin
      dec_slot = pr_hit_idx[FRAMES];
    end else if (pr_flags[FRAMES].empty_found) begin
      dec_slot = pr_empty[FRAMES];
    end else begin
      dec_slot = pr_victim[FRAMES];
    end
  end

  assign fault_nxt = (!dec_hit && (fault_r != {CB{1'b1}})) ? fault_r + CB'(1) : fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= '0;
    end else if (cmd.apply) begin
      fault_r <= end_r ? '0 : fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.apply) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_hit_r      <= dec_hit;
      out_frame_r    <= dec_slot;
      out_ev_valid_r <= dec_evict;
      out_ev_page_r  <= dec_evict ? pr_vpage[FRAMES] : '0;
      out_fault_r    <= fault_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.frame         = out_frame_r;
  assign out_ch.evicted_valid = out_ev_valid_r;
  assign out_ch.evicted_page  = out_ev_page_r;
  assign out_ch.fault_count   = out_fault_r;

  `ASSERT_ALWAYS(a_one_probe, $onehot0(tok_vec), "more than one reference in the cell row")
  `ASSERT_IMPLY(a_idle_empty, state_r == S_IDLE, tok_vec == '0, "cell row busy while idle")
  `ASSERT_NEXT(a_fault_mono, cmd.apply && !cmd.clear, fault_r >= $past(fault_r), "fault count fell")
  `ASSERT_IMPLY(a_hit_no_evict, out_ch.valid && out_ch.hit, !out_ch.evicted_valid, "eviction on hit")

endmodule
